@@ hdl/lbvs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package lbvs_pkg;
    localparam int JOINT_COUNT_DEF = 64;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int WORDS_PER_JOINT = 32;
    localparam int WEIGHT_FRAC     = 16;
    localparam int ACC_W           = 48;

    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_CONTRIB = 1'b1;

    typedef struct packed {
        logic start;
        logic signed [63:0] num;
        logic signed [31:0] den;
    } div_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        begin
            if (v > 66'sd2147483647)
                r = 32'sh7fffffff;
            else if (v < -66'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        logic signed [47:0] r;
        begin
            if (v > 50'sh0_7fff_ffff_ffff)
                r = 48'sh7fff_ffff_ffff;
            else if (v < -50'sh0_8000_0000_0000)
                r = 48'sh8000_0000_0000;
            else
                r = v[47:0];
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat48to32(input logic signed [47:0] v);
        logic signed [31:0] r;
        begin
            if (v > 48'sd2147483647)
                r = 32'sh7fffffff;
            else if (v < -48'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction
endpackage
`default_nettype wire

@@ hdl/lbvs_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lbvs_div
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  lbvs_pkg::div_req_t     req,
    output logic                   busy,
    output logic signed [31:0]     quo
);
    import lbvs_pkg::*;

    logic [63:0] rem_reg, rem_next;
    logic [63:0] q_reg, q_next;
    logic [31:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [64:0] trial;
    logic [64:0] qmag;

    always_comb
    begin
        rem_next = rem_reg;
        q_next   = q_reg;
        d_next   = d_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        trial    = '0;
        if (req.start)
        begin
            rem_next = '0;
            q_next   = req.num[63] ? 64'(-req.num) : req.num;
            d_next   = req.den[31] ? 32'(-req.den) : req.den;
            neg_next = req.num[63] ^ req.den[31];
            cnt_next = 7'd64;
        end
        else if (cnt_reg != 7'd0)
        begin
            trial = {rem_reg, q_reg[63]} - {33'd0, d_reg};
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                q_next   = {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[62:0], q_reg[63]};
                q_next   = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign busy = (cnt_reg != 7'd0);
    assign qmag = neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg};
    assign quo  = sat32({qmag[64], qmag});
endmodule
`default_nettype wire

@@ hdl/linear_blend_vertex_skinning.sv @@
`timescale 1ns / 1ps
`default_nettype none
// a contribution runs four 4x4 point transforms on one shared 32x32 multiplier (16 products
// each, read, multiply and accumulate states a product, then a row state) and up to twelve
// homogeneous divides on one radix-2 divider, then six weight products on the same
// multiplier. the result register lets the next item start while a finished vertex waits to
// be taken, except a last contribution, which waits until that vertex has gone
module linear_blend_vertex_skinning
    import lbvs_pkg::*;
#(
    parameter int JOINT_COUNT = lbvs_pkg::JOINT_COUNT_DEF,
    parameter int FRAC_BITS   = lbvs_pkg::FRAC_BITS_DEF
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_stall,
    input  wire                func,
    input  wire  [5:0]         joint_index,
    input  wire  [4:0]         word_index,
    input  wire  signed [31:0] word_value,
    input  wire  signed [31:0] pos_x,
    input  wire  signed [31:0] pos_y,
    input  wire  signed [31:0] pos_z,
    input  wire  signed [31:0] norm_x,
    input  wire  signed [31:0] norm_y,
    input  wire  signed [31:0] norm_z,
    input  wire  [16:0]        weight,
    input  wire                last,
    output logic               out_valid,
    input  wire                out_stall,
    output logic signed [31:0] skinned_x,
    output logic signed [31:0] skinned_y,
    output logic signed [31:0] skinned_z,
    output logic signed [31:0] skinned_nx,
    output logic signed [31:0] skinned_ny,
    output logic signed [31:0] skinned_nz
);
    localparam int JW   = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam int AW   = JW + 5;
    localparam int MEMD = JOINT_COUNT * WORDS_PER_JOINT;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_ACC   = 4'd3;
    localparam logic [3:0] S_ROW   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_DIVW  = 4'd6;
    localparam logic [3:0] S_NEXT  = 4'd7;
    localparam logic [3:0] S_WMUL  = 4'd8;
    localparam logic [3:0] S_WACC  = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    logic signed [31:0] mem [0:MEMD-1];
    logic signed [31:0] rd_reg;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  pass_reg, pass_next;
    logic [1:0]  row_reg, row_next;
    logic [1:0]  col_reg, col_next;
    logic [2:0]  lane_reg, lane_next;
    logic [JW-1:0] joint_reg;
    logic        jvalid_reg;
    logic        last_reg;
    logic [16:0] weight_reg;
    logic signed [31:0] v_reg [0:5];
    logic signed [31:0] r_reg [0:3];
    logic signed [63:0] prod_reg;
    logic signed [65:0] hi_reg, hi_next;
    logic [17+24:0]     lo_reg, lo_next;
    logic signed [47:0] acc_reg [0:5];
    logic signed [31:0] res_reg [0:5];
    logic        out_valid_reg;

    logic [AW-1:0] rd_addr;
    logic [JW-1:0] joint_sel;
    logic signed [31:0] mul_a, mul_b;
    logic [2:0]  vbase;
    logic signed [65:0] rowsum;
    logic signed [31:0] rowsat;
    div_req_t    dreq;
    logic        dbusy;
    logic signed [31:0] dquo;
    logic signed [49:0] wsum;
    logic        wr_en;

    lbvs_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .busy  (dbusy),
        .quo   (dquo)
    );

    assign vbase = pass_reg[1] ? 3'd3 : 3'd0;
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && in_valid && func == FUNC_CONTRIB
                      && last);
    assign wr_en = in_valid && !in_stall && func == FUNC_WRITE
                   && {26'd0, joint_index} < JOINT_COUNT;
    assign joint_sel = JW'({{JW{1'b0}}, joint_index});
    assign rd_addr = {joint_reg, pass_reg[0], row_reg, col_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[{joint_sel, word_index}] <= word_value;
        rd_reg <= mem[rd_addr];
    end

    always_comb
    begin
        mul_a = rd_reg;
        mul_b = 32'sd1 <<< FRAC_BITS;
        if (state_reg == S_WMUL)
        begin
            mul_a = jvalid_reg ? v_reg[lane_reg] : 32'sd0;
            mul_b = {15'd0, weight_reg};
        end
        else if (col_reg != 2'd3)
            mul_b = v_reg[vbase + {1'b0, col_reg}];
    end

    assign rowsum = hi_reg + 66'(lo_reg >> FRAC_BITS);
    assign rowsat = sat32(rowsum);
    assign wsum = 50'(acc_reg[lane_reg]) + 50'(prod_reg >>> WEIGHT_FRAC);

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        lane_next  = lane_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        dreq       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall && func == FUNC_CONTRIB)
                begin
                    pass_next = '0;
                    row_next  = '0;
                    col_next  = '0;
                    hi_next   = '0;
                    lo_next   = '0;
                    state_next = ({26'd0, joint_index} < JOINT_COUNT) ? S_RD : S_WMUL;
                    lane_next = '0;
                end
            end
            S_RD:   state_next = S_MUL;
            S_MUL:  state_next = S_ACC;
            S_ACC:
            begin
                hi_next = hi_reg + 66'(prod_reg >>> FRAC_BITS);
                lo_next = lo_reg + 42'(prod_reg[FRAC_BITS-1:0]);
                if (col_reg == 2'd3)
                    state_next = S_ROW;
                else
                begin
                    col_next = col_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            S_ROW:
            begin
                hi_next  = '0;
                lo_next  = '0;
                col_next = '0;
                if (row_reg == 2'd3)
                begin
                    lane_next = '0;
                    state_next = (rowsat != 32'sd0) ? S_DIV : S_NEXT;
                end
                else
                begin
                    row_next = row_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            S_DIV:
            begin
                dreq.start = 1'b1;
                dreq.num   = 64'(r_reg[lane_reg[1:0]]) <<< FRAC_BITS;
                dreq.den   = r_reg[3];
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (!dbusy)
                begin
                    if (lane_reg == 3'd2)
                        state_next = S_NEXT;
                    else
                    begin
                        lane_next = lane_reg + 3'd1;
                        state_next = S_DIV;
                    end
                end
            end
            S_NEXT:
            begin
                row_next = '0;
                lane_next = '0;
                if (pass_reg == 2'd3)
                    state_next = S_WMUL;
                else
                begin
                    pass_next = pass_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            S_WMUL: state_next = S_WACC;
            S_WACC:
            begin
                if (lane_reg == 3'd5)
                    state_next = (last_reg) ? S_EMIT : S_IDLE;
                else
                begin
                    lane_next = lane_reg + 3'd1;
                    state_next = S_WMUL;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
                acc_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_WACC)
                acc_reg[lane_reg] <= sat48(wsum);
            if (state_reg == S_EMIT && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
                for (int i = 0; i < 6; i++)
                    acc_reg[i] <= '0;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pass_reg <= pass_next;
        row_reg  <= row_next;
        col_reg  <= col_next;
        lane_reg <= lane_next;
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        prod_reg <= mul_a * mul_b;
        if (state_reg == S_IDLE && in_valid && !in_stall)
        begin
            joint_reg  <= joint_sel;
            jvalid_reg <= {26'd0, joint_index} < JOINT_COUNT;
            last_reg   <= last;
            weight_reg <= weight;
            v_reg[0] <= pos_x;
            v_reg[1] <= pos_y;
            v_reg[2] <= pos_z;
            v_reg[3] <= norm_x;
            v_reg[4] <= norm_y;
            v_reg[5] <= norm_z;
        end
        if (state_reg == S_ROW)
        begin
            r_reg[row_reg] <= rowsat;
            // zero w keeps the transformed row values
            if (row_reg == 2'd3 && rowsat == 32'sd0)
            begin
                v_reg[vbase]        <= r_reg[0];
                v_reg[vbase + 3'd1] <= r_reg[1];
                v_reg[vbase + 3'd2] <= r_reg[2];
            end
        end
        if (state_reg == S_DIVW && !dbusy)
            v_reg[vbase + lane_reg] <= dquo;
        if (state_reg == S_EMIT && (!out_valid_reg || !out_stall))
            for (int i = 0; i < 6; i++)
                res_reg[i] <= sat48to32(acc_reg[i]);
    end

    assign out_valid  = out_valid_reg;
    assign skinned_x  = res_reg[0];
    assign skinned_y  = res_reg[1];
    assign skinned_z  = res_reg[2];
    assign skinned_nx = res_reg[3];
    assign skinned_ny = res_reg[4];
    assign skinned_nz = res_reg[5];

`ifndef SYNTH
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall) else $error("accepted while busy");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> !dbusy) else $error("divider restarted while busy");
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && state_next == S_IDLE |=> out_valid) else $error("result lost");
`endif
endmodule
`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import lbvs_pkg::*;

    typedef struct {
        logic               func;
        logic [5:0]         joint;
        logic [4:0]         word;
        logic signed [31:0] value;
        logic signed [31:0] p [3];
        logic signed [31:0] n [3];
        logic [16:0]        wgt;
        logic               last;
    } skin_item_t;

    typedef struct {
        logic signed [31:0] p [3];
        logic signed [31:0] n [3];
    } vertex_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic func = 1'b0;
    logic [5:0] joint_index = '0;
    logic [4:0] word_index = '0;
    logic signed [31:0] word_value = '0;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [31:0] norm_x = '0, norm_y = '0, norm_z = '0;
    logic [16:0] weight = '0;
    logic last = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] skinned_x, skinned_y, skinned_z;
    logic signed [31:0] skinned_nx, skinned_ny, skinned_nz;

    linear_blend_vertex_skinning dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    skin_item_t pending_items [$];
    vertex_t    expected_vertices [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_sender = 1'b0;
    int failures = 0;

    // predictor state
    logic signed [31:0] palette [64][32];
    logic signed [47:0] pos_acc [3];
    logic signed [47:0] norm_acc [3];

    function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return 32'sh7fffffff;
        if (v < -128'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [47:0] clamp48(logic signed [127:0] v);
        if (v > 128'sh7fff_ffff_ffff)
            return 48'sh7fff_ffff_ffff;
        if (v < -128'sh8000_0000_0000)
            return 48'sh8000_0000_0000;
        return v[47:0];
    endfunction

    // point transform with w = 1 and homogeneous divide; base 0 inverse bind, 16 pose
    task automatic apply_matrix(input int j, input int base, inout logic signed [31:0] v [3]);
        logic signed [127:0] acc;
        logic signed [127:0] num;
        logic signed [31:0] r [4];
        logic signed [31:0] opnd;
        for (int i = 0; i < 4; i++)
        begin
            acc = 0;
            for (int k = 0; k < 4; k++)
            begin
                opnd = (k == 3) ? 32'sh0001_0000 : v[k];
                acc += 128'(palette[j][base + i * 4 + k]) * 128'(opnd);
            end
            r[i] = clamp32(acc >>> FRAC_BITS_DEF);
        end
        for (int i = 0; i < 3; i++)
        begin
            if (r[3] != 0)
            begin
                num = 128'(r[i]) <<< FRAC_BITS_DEF;
                v[i] = clamp32(num / 128'(r[3]));
            end
            else
                v[i] = r[i];
        end
    endtask

    task automatic predict_skin(input skin_item_t it);
        logic signed [31:0] pv [3];
        logic signed [31:0] nv [3];
        logic signed [127:0] prod;
        vertex_t vx;
        if (it.func == FUNC_WRITE)
        begin
            palette[it.joint][it.word] = it.value;
            return;
        end
        pv = it.p;
        nv = it.n;
        apply_matrix(it.joint, 0, pv);
        apply_matrix(it.joint, 16, pv);
        apply_matrix(it.joint, 0, nv);
        apply_matrix(it.joint, 16, nv);
        for (int i = 0; i < 3; i++)
        begin
            prod = (128'(pv[i]) * 128'(signed'({1'b0, it.wgt}))) >>> WEIGHT_FRAC;
            pos_acc[i] = clamp48(128'(pos_acc[i]) + prod);
            prod = (128'(nv[i]) * 128'(signed'({1'b0, it.wgt}))) >>> WEIGHT_FRAC;
            norm_acc[i] = clamp48(128'(norm_acc[i]) + prod);
        end
        if (it.last)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vx.p[i] = clamp32(128'(pos_acc[i]));
                vx.n[i] = clamp32(128'(norm_acc[i]));
                pos_acc[i] = 0;
                norm_acc[i] = 0;
            end
            expected_vertices.insert(expected_vertices.size(), vx);
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        skin_item_t it;
        if (rst_n)
        begin
            if (!(in_valid && in_stall))
            begin
                if (pending_items.size() > 0 && !hold_sender
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    it = pending_items.pop_front();
                    predict_skin(it);
                    in_valid <= 1'b1;
                    func <= it.func;
                    joint_index <= it.joint;
                    word_index <= it.word;
                    word_value <= it.value;
                    pos_x <= it.p[0];
                    pos_y <= it.p[1];
                    pos_z <= it.p[2];
                    norm_x <= it.n[0];
                    norm_y <= it.n[1];
                    norm_z <= it.n[2];
                    weight <= it.wgt;
                    last <= it.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        vertex_t ex;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_vertices.size() == 0)
                begin
                    $error("unexpected result transfer");
                    failures++;
                end
                else
                begin
                    ex = expected_vertices.pop_front();
                    if (skinned_x !== ex.p[0])
                    begin
                        $error("skinned_x exp %0d got %0d", ex.p[0], skinned_x);
                        failures++;
                    end
                    if (skinned_y !== ex.p[1])
                    begin
                        $error("skinned_y exp %0d got %0d", ex.p[1], skinned_y);
                        failures++;
                    end
                    if (skinned_z !== ex.p[2])
                    begin
                        $error("skinned_z exp %0d got %0d", ex.p[2], skinned_z);
                        failures++;
                    end
                    if (skinned_nx !== ex.n[0])
                    begin
                        $error("skinned_nx exp %0d got %0d", ex.n[0], skinned_nx);
                        failures++;
                    end
                    if (skinned_ny !== ex.n[1])
                    begin
                        $error("skinned_ny exp %0d got %0d", ex.n[1], skinned_ny);
                        failures++;
                    end
                    if (skinned_nz !== ex.n[2])
                    begin
                        $error("skinned_nz exp %0d got %0d", ex.n[2], skinned_nz);
                        failures++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'(signed'($urandom_range(131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    // small matrix entries keep values in range most of the time
    function automatic logic signed [31:0] rand_entry(int idx);
        if ($urandom_range(19) == 0)
            return rand_word();
        if (idx % 4 == 3 && idx % 16 >= 12)
            return (idx % 16 == 15) ? 32'sh0001_0000 : 32'sh0;
        return 32'(signed'($urandom_range(262144)) - 131072);
    endfunction

    task automatic queue_write(input int j, input int w, input logic signed [31:0] v,
                               input logic lst);
        skin_item_t it;
        it.func = FUNC_WRITE;
        it.joint = 6'(j);
        it.word = 5'(w);
        it.value = v;
        it.p = '{$urandom, $urandom, $urandom};
        it.n = '{$urandom, $urandom, $urandom};
        it.wgt = 17'($urandom);
        it.last = lst;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic queue_contrib(input int j, input logic [16:0] wg, input logic lst,
                                 input bit extreme);
        skin_item_t it;
        it.func = FUNC_CONTRIB;
        it.joint = 6'(j);
        it.word = 5'($urandom);
        it.value = $urandom;
        for (int i = 0; i < 3; i++)
        begin
            it.p[i] = extreme ? rand_word() : 32'(signed'($urandom_range(2097152)) - 1048576);
            it.n[i] = extreme ? rand_word() : 32'(signed'($urandom_range(131072)) - 65536);
        end
        it.wgt = wg;
        it.last = lst;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || in_valid || expected_vertices.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int nc;
        logic [16:0] wg;
        for (int i = 0; i < 3; i++)
        begin
            pos_acc[i] = 0;
            norm_acc[i] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: fill the low joints fully, contributions only use those
        for (int j = 0; j < 8; j++)
            for (int w = 0; w < 32; w++)
                queue_write(j, w, rand_entry(w), w[0]);
        // joint 1 identity, joint 2 zero w row, joint 3 extremes
        for (int w = 0; w < 32; w++)
        begin
            queue_write(1, w, (w % 16) % 5 == 0 ? 32'sh0001_0000 : 32'sh0, 1'b0);
            queue_write(2, w, (w % 16) >= 12 ? 32'sh0 : rand_entry(w), 1'b0);
            queue_write(3, w, w[0] ? 32'sh7fffffff : 32'sh80000000, 1'b1);
        end
        queue_contrib(1, 17'd65536, 1'b1, 1'b0);
        queue_contrib(1, 17'd0, 1'b1, 1'b1);
        queue_contrib(1, 17'h1ffff, 1'b0, 1'b1);
        queue_contrib(1, 17'h1ffff, 1'b1, 1'b1);
        queue_contrib(2, 17'd32768, 1'b1, 1'b1);
        queue_contrib(3, 17'h1ffff, 1'b0, 1'b1);
        queue_contrib(3, 17'h1ffff, 1'b1, 1'b1);
        queue_contrib(7, 17'd65536, 1'b1, 1'b1);
        queue_contrib(0, 17'd65536, 1'b1, 1'b0);
        wait_drained();

        // random phases; in phase 1 the sender pauses with items still pending until the results drain
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            nc = 0;
            while (nc < 96)
            begin
                if ($urandom_range(9) < 2)
                begin
                    queue_write($urandom_range(63), $urandom_range(31),
                                rand_entry($urandom_range(31)), 1'($urandom));
                    nc++;
                end
                else
                begin
                    wg = ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
                    queue_contrib($urandom_range(7), wg, $urandom_range(2) == 0,
                                  $urandom_range(7) == 0);
                    nc++;
                end
            end
            queue_contrib($urandom_range(7), 17'd65536, 1'b1, 1'b0);
            if (ph == 1)
            begin
                while (pending_items.size() > 48)
                    @(posedge clk);
                hold_sender = 1'b1;
                while (in_valid || expected_vertices.size() > 0)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
            wait_drained();
        end
        repeat (2000) @(posedge clk);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #400ms;
        $display("FAILURE");
        $finish;
    end
endmodule

@@ files.f @@
hdl/lbvs_pkg.sv
hdl/lbvs_div.sv
hdl/linear_blend_vertex_skinning.sv
bench/tb.sv
